// ===== hdl/ihpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpf_pkg
// shared types, codes and constants of the ipv4 header packet filter
// ----------------------------------------------------------------------------
package ihpf_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] UDP_PORT_RESET = 16'd53;

    // ip protocol numbers
    localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
    localparam logic [7:0] IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0] IP_PROTO_UDP  = 8'd17;

    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

    // fragment word fields
    localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1FFF;
    localparam logic [15:0] FRAG_MORE_MASK   = 16'h2000;

    // tcp flag bits
    localparam logic [7:0] TCP_FIN = 8'h01;
    localparam logic [7:0] TCP_SYN = 8'h02;
    localparam logic [7:0] TCP_RST = 8'h04;
    localparam logic [7:0] TCP_PSH = 8'h08;
    localparam logic [7:0] TCP_ACK = 8'h10;
    localparam logic [7:0] TCP_URG = 8'h20;
    localparam logic [7:0] TCP_LOW_SIX = 8'h3F;

    // l4 header sizes in bytes
    localparam logic [6:0] ICMP_HDR_BYTES = 7'd8;
    localparam logic [6:0] UDP_HDR_BYTES  = 7'd8;
    localparam logic [6:0] TCP_HDR_BYTES  = 7'd20;

    typedef enum logic [3:0] {
        REASON_NONE     = 4'd0,
        REASON_SHORT    = 4'd1,
        REASON_SPOOFED  = 4'd2,
        REASON_FRAGMENT = 4'd3,
        REASON_ECHO     = 4'd4,
        REASON_UDP_PORT = 4'd5,
        REASON_NULL     = 4'd6,
        REASON_SYNFIN   = 4'd7,
        REASON_SYNRST   = 4'd8,
        REASON_XMAS     = 4'd9,
        REASON_LONE_ACK = 4'd10
    } reason_t;

    typedef enum logic [1:0] {
        CLASS_OTHER = 2'd0,
        CLASS_ICMP  = 2'd1,
        CLASS_UDP   = 2'd2,
        CLASS_TCP   = 2'd3
    } proto_class_t;

    // classification word handed from front to back
    typedef struct packed {
        logic         short_ip;
        logic         spoofed;
        logic         fragment;
        proto_class_t proto;
        logic         short_l4;
        logic         echo;
        logic         udp_miss;
        logic         tcp_null;
        logic         tcp_synfin;
        logic         tcp_synrst;
        logic         tcp_xmas;
        logic         tcp_lone_ack;
    } class_t;

endpackage

// ===== hdl/ihpf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpf_front
// accepts header words and registers their check results
// ----------------------------------------------------------------------------
module ihpf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [15:0]           allowed_udp_port,
    input  logic [31:0]           source_address,
    input  logic [15:0]           fragment_field,
    input  logic [7:0]            protocol_number,
    input  logic [3:0]            header_words,
    input  logic [15:0]           packet_length,
    input  logic [7:0]            icmp_type,
    input  logic [15:0]           udp_source_port,
    input  logic [15:0]           udp_dest_port,
    input  logic [7:0]            tcp_flag_bits,
    input  logic                  connection_confirmed,
    input  logic                  push_ok,
    output logic                  valid,
    output ihpf_pkg::class_t      cls
);
    import ihpf_pkg::*;

    logic [5:0]   hdr_bytes;
    logic [6:0]   l4_need;
    logic [6:0]   l4_bytes;
    class_t       cls_next;
    class_t       cls_reg;
    logic         valid_reg;
    logic         valid_next;

    always_comb
    begin
        hdr_bytes = {header_words, 2'b00};
        cls_next  = '0;

        unique case (protocol_number)
            IP_PROTO_ICMP:
            begin
                cls_next.proto = CLASS_ICMP;
                l4_bytes       = ICMP_HDR_BYTES;
            end
            IP_PROTO_UDP:
            begin
                cls_next.proto = CLASS_UDP;
                l4_bytes       = UDP_HDR_BYTES;
            end
            IP_PROTO_TCP:
            begin
                cls_next.proto = CLASS_TCP;
                l4_bytes       = TCP_HDR_BYTES;
            end
            default:
            begin
                cls_next.proto = CLASS_OTHER;
                l4_bytes       = '0;
            end
        endcase

        l4_need = {1'b0, hdr_bytes} + l4_bytes;

        cls_next.short_ip = packet_length < {10'd0, hdr_bytes};
        cls_next.short_l4 = packet_length < {9'd0, l4_need};

        // loopback, private 10/8 and 172.16/12, multicast, limited broadcast
        cls_next.spoofed = (source_address[31:24] == 8'h7F)
                        || (source_address[31:24] == 8'h0A)
                        || (source_address[31:20] == 12'hAC1)
                        || (source_address[31:28] == 4'hE)
                        || (source_address == 32'hFFFF_FFFF);

        cls_next.fragment = ((fragment_field & FRAG_OFFSET_MASK) != '0)
                         || ((fragment_field & FRAG_MORE_MASK) != '0);

        cls_next.echo     = icmp_type == ICMP_ECHO_REQUEST;
        cls_next.udp_miss = (udp_source_port != allowed_udp_port)
                         && (udp_dest_port != allowed_udp_port);

        cls_next.tcp_null   = tcp_flag_bits == '0;
        cls_next.tcp_synfin = (tcp_flag_bits & (TCP_SYN | TCP_FIN)) == (TCP_SYN | TCP_FIN);
        cls_next.tcp_synrst = (tcp_flag_bits & (TCP_SYN | TCP_RST)) == (TCP_SYN | TCP_RST);
        cls_next.tcp_xmas   = (tcp_flag_bits & (TCP_FIN | TCP_PSH | TCP_URG))
                           == (TCP_FIN | TCP_PSH | TCP_URG);
        cls_next.tcp_lone_ack = ((tcp_flag_bits & TCP_LOW_SIX) == TCP_ACK)
                             && !connection_confirmed;
    end

    // holds while the queue is full, otherwise hands on and reloads
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (push_ok)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cls_reg <= cls_next;
    end

    assign valid = valid_reg;
    assign cls   = cls_reg;

    // a held word must not be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !push_ok) |-> !load)
        else $error("front word overwritten while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !push_ok && !load) |=> (valid_reg && $stable(cls_reg)))
        else $error("front word lost while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded word not marked valid");

endmodule

// ===== hdl/ihpf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpf_queue
// short fifo of classification words between front and back
// ----------------------------------------------------------------------------
module ihpf_queue #(
    parameter int unsigned DEPTH = ihpf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ihpf_pkg::class_t      push_word,
    input  logic                  pop,
    output logic                  full,
    output logic                  empty,
    output ihpf_pkg::class_t      head_word
);
    import ihpf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    class_t           entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == FULL_CNT;
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    assign head_word = entry_reg[rd_ptr_reg];

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== hdl/ihpf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihpf_back
// resolves check priority into the verdict and registers the result
// ----------------------------------------------------------------------------
module ihpf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  ihpf_pkg::class_t      cls,
    output logic                  result_valid,
    output logic                  drop_packet,
    output logic [3:0]            drop_reason
);
    import ihpf_pkg::*;

    reason_t reason_next;
    reason_t reason_reg;
    logic    strobe_reg;

    // first failing check decides
    always_comb
    begin
        if (cls.short_ip)
            reason_next = REASON_SHORT;
        else if (cls.spoofed)
            reason_next = REASON_SPOOFED;
        else if (cls.fragment)
            reason_next = REASON_FRAGMENT;
        else
        begin
            case (cls.proto)
                CLASS_ICMP:
                begin
                    if (cls.short_l4)
                        reason_next = REASON_SHORT;
                    else if (cls.echo)
                        reason_next = REASON_ECHO;
                    else
                        reason_next = REASON_NONE;
                end
                CLASS_UDP:
                begin
                    if (cls.short_l4)
                        reason_next = REASON_SHORT;
                    else if (cls.udp_miss)
                        reason_next = REASON_UDP_PORT;
                    else
                        reason_next = REASON_NONE;
                end
                CLASS_TCP:
                begin
                    if (cls.short_l4)
                        reason_next = REASON_SHORT;
                    else if (cls.tcp_null)
                        reason_next = REASON_NULL;
                    else if (cls.tcp_synfin)
                        reason_next = REASON_SYNFIN;
                    else if (cls.tcp_synrst)
                        reason_next = REASON_SYNRST;
                    else if (cls.tcp_xmas)
                        reason_next = REASON_XMAS;
                    else if (cls.tcp_lone_ack)
                        reason_next = REASON_LONE_ACK;
                    else
                        reason_next = REASON_NONE;
                end
                default:
                    reason_next = REASON_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            reason_reg <= reason_next;
    end

    assign result_valid = strobe_reg;
    assign drop_reason  = reason_reg;
    assign drop_packet  = reason_reg != REASON_NONE;

    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> result_valid)
        else $error("taken word gave no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && cls.short_ip) |=> (drop_reason == REASON_SHORT))
        else $error("short header not ranked first");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (drop_reason <= REASON_LONE_ACK))
        else $error("reason code out of range");

endmodule

// ===== hdl/ipv4_header_packet_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_packet_filter
// stateless accept or drop verdict, while busy is low, for one parsed ipv4 header per cycle
// ----------------------------------------------------------------------------
// a header word is taken at any clock edge with start high and busy low, and
// one can follow every cycle. its verdict shows on drop_packet and
// drop_reason for exactly one cycle, marked by result_valid, once the word
// has passed the front register, queue slot and verdict register.
// results cannot be held off: the back end drains the queue every cycle, so
// busy stays low in normal use and only rises if the queue is full. the
// allowed udp port is written through cfg_valid / cfg_data (cfg_ready is
// always high); write it only while no word is in flight.
// ----------------------------------------------------------------------------
module ipv4_header_packet_filter #(
    parameter int unsigned QUEUE_DEPTH = ihpf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    // command side
    input  logic        start,
    output logic        busy,
    input  logic [31:0] source_address,
    input  logic [15:0] fragment_field,
    input  logic [7:0]  protocol_number,
    input  logic [3:0]  header_words,
    input  logic [15:0] packet_length,
    input  logic [7:0]  icmp_type,
    input  logic [15:0] udp_source_port,
    input  logic [15:0] udp_dest_port,
    input  logic [7:0]  tcp_flag_bits,
    input  logic        connection_confirmed,

    // result side
    output logic        result_valid,
    output logic        drop_packet,
    output logic [3:0]  drop_reason,

    // allowed udp port register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import ihpf_pkg::*;

    logic [15:0] allowed_udp_port_reg;
    logic        accept;
    logic        front_valid;
    class_t      front_cls;
    logic        q_full;
    logic        q_empty;
    class_t      q_head;
    logic        push_ok;

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            allowed_udp_port_reg <= UDP_PORT_RESET;
        else if (cfg_valid && cfg_ready)
            allowed_udp_port_reg <= cfg_data;
    end

    // front stage hands its word to the queue whenever there is room
    assign push_ok = front_valid && !q_full;

    // busy only while the front holds a word the queue cannot take
    assign busy   = front_valid && q_full;
    assign accept = start && !busy;

    ihpf_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .load                 (accept),
        .allowed_udp_port     (allowed_udp_port_reg),
        .source_address       (source_address),
        .fragment_field       (fragment_field),
        .protocol_number      (protocol_number),
        .header_words         (header_words),
        .packet_length        (packet_length),
        .icmp_type            (icmp_type),
        .udp_source_port      (udp_source_port),
        .udp_dest_port        (udp_dest_port),
        .tcp_flag_bits        (tcp_flag_bits),
        .connection_confirmed (connection_confirmed),
        .push_ok              (push_ok),
        .valid                (front_valid),
        .cls                  (front_cls)
    );

    ihpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_ok),
        .push_word (front_cls),
        .pop       (!q_empty),
        .full      (q_full),
        .empty     (q_empty),
        .head_word (q_head)
    );

    // back end never stalls: it takes the queue head in every cycle the queue is not empty
    ihpf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (!q_empty),
        .cls          (q_head),
        .result_valid (result_valid),
        .drop_packet  (drop_packet),
        .drop_reason  (drop_reason)
    );

    // verdict and reason agree
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !drop_packet) |-> (drop_reason == REASON_NONE))
        else $error("accept with nonzero reason");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && drop_packet) |-> (drop_reason != REASON_NONE))
        else $error("drop without reason");

    // a lone word through an empty pipe comes out after the front register, queue slot and verdict register
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !front_valid && q_empty) |-> ##3 result_valid)
        else $error("result missing three cycles after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> front_valid)
        else $error("busy with empty front stage");

endmodule

// ===== tb/tb_ipv4_header_packet_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_header_packet_filter
// self-checking bench for the ipv4 header packet filter
// ----------------------------------------------------------------------------
// directed header words cover each drop reason, the address and flag edge
// cases and the port register extremes. random traffic then follows: mostly
// well-formed headers with random content, plus noise and broken headers.
// every accepted word is run through a local verdict model and the verdict
// is queued. each result strobe is checked field by field against the oldest
// queued verdict
// ----------------------------------------------------------------------------
module tb_ipv4_header_packet_filter;

    import ihpf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    // allow some slack past the last result
    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 550;
    localparam int IDLE_PERCENT  = 36;
    localparam int MAX_REPORTS   = 10;

    // codes the package does not name
    localparam logic [7:0]  PROTO_UNLISTED = 8'd255;
    localparam logic [15:0] FRAG_DONT_FRAG = 16'h4000;
    localparam logic [7:0]  TCP_ECE_CWR    = 8'hC0;

    // one parsed header, as driven onto the command side
    typedef struct {
        logic [31:0] src_addr;
        logic [15:0] frag_word;
        logic [7:0]  proto;
        logic [3:0]  hdr_words;
        logic [15:0] pkt_len;
        logic [7:0]  icmp_kind;
        logic [15:0] udp_sport;
        logic [15:0] udp_dport;
        logic [7:0]  tcp_flags;
        logic        conf;
    } hdr_item_t;

    typedef struct packed {
        logic    drop;
        reason_t reason;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] source_address;
    logic [15:0] fragment_field;
    logic [7:0]  protocol_number;
    logic [3:0]  header_words;
    logic [15:0] packet_length;
    logic [7:0]  icmp_type;
    logic [15:0] udp_source_port;
    logic [15:0] udp_dest_port;
    logic [7:0]  tcp_flag_bits;
    logic        connection_confirmed;
    logic        result_valid;
    logic        drop_packet;
    logic [3:0]  drop_reason;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // local copy of the port register, tracks every write
    logic [15:0] allowed_port = UDP_PORT_RESET;
    // verdicts of accepted words, oldest first
    verdict_t    pending_verdicts [$];
    verdict_t    oldest_verdict;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    // sender gaps on or off
    bit          gaps_on = 1'b1;

    ipv4_header_packet_filter u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .source_address       (source_address),
        .fragment_field       (fragment_field),
        .protocol_number      (protocol_number),
        .header_words         (header_words),
        .packet_length        (packet_length),
        .icmp_type            (icmp_type),
        .udp_source_port      (udp_source_port),
        .udp_dest_port        (udp_dest_port),
        .tcp_flag_bits        (tcp_flag_bits),
        .connection_confirmed (connection_confirmed),
        .result_valid         (result_valid),
        .drop_packet          (drop_packet),
        .drop_reason          (drop_reason),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // verdict model: first failing check decides
    function automatic verdict_t predict_verdict(hdr_item_t h, logic [15:0] port);
        int unsigned hdr_bytes;
        int unsigned plen;
        logic [31:0] a;
        logic [7:0]  fl;
        logic        spoofed;
        reason_t     why;
        verdict_t    v;
        hdr_bytes = 32'(h.hdr_words) * 4;
        plen      = 32'(h.pkt_len);
        a         = h.src_addr;
        fl        = h.tcp_flags;
        // loopback, private 10/8 and 172.16/12, multicast, limited broadcast
        spoofed = (a[31:24] == 8'h7F) || (a[31:24] == 8'h0A) ||
                  (a[31:20] == 12'hAC1) || (a[31:28] == 4'hE) ||
                  (a == 32'hFFFF_FFFF);
        why = REASON_NONE;
        if (plen < hdr_bytes)
            why = REASON_SHORT;
        else if (spoofed)
            why = REASON_SPOOFED;
        else if ((h.frag_word & (FRAG_OFFSET_MASK | FRAG_MORE_MASK)) != 16'd0)
            why = REASON_FRAGMENT;
        else if (h.proto == IP_PROTO_ICMP)
        begin
            if (plen < hdr_bytes + 32'(ICMP_HDR_BYTES))
                why = REASON_SHORT;
            else if (h.icmp_kind == ICMP_ECHO_REQUEST)
                why = REASON_ECHO;
        end
        else if (h.proto == IP_PROTO_UDP)
        begin
            if (plen < hdr_bytes + 32'(UDP_HDR_BYTES))
                why = REASON_SHORT;
            else if (h.udp_sport != port && h.udp_dport != port)
                why = REASON_UDP_PORT;
        end
        else if (h.proto == IP_PROTO_TCP)
        begin
            if (plen < hdr_bytes + 32'(TCP_HDR_BYTES))
                why = REASON_SHORT;
            else if (fl == 8'd0)
                why = REASON_NULL;
            else if ((fl & (TCP_SYN | TCP_FIN)) == (TCP_SYN | TCP_FIN))
                why = REASON_SYNFIN;
            else if ((fl & (TCP_SYN | TCP_RST)) == (TCP_SYN | TCP_RST))
                why = REASON_SYNRST;
            else if ((fl & (TCP_FIN | TCP_PSH | TCP_URG)) == (TCP_FIN | TCP_PSH | TCP_URG))
                why = REASON_XMAS;
            else if ((fl & TCP_LOW_SIX) == TCP_ACK && !h.conf)
                why = REASON_LONE_ACK;
        end
        v.drop   = (why != REASON_NONE);
        v.reason = why;
        return v;
    endfunction

    // header that passes every check for the given protocol
    function automatic hdr_item_t clean_header(logic [7:0] proto);
        hdr_item_t h;
        h.src_addr  = 32'hC0A8_0001;
        h.frag_word = 16'h0000;
        h.proto     = proto;
        h.hdr_words = 4'd5;
        h.pkt_len   = 16'd60;
        h.icmp_kind = 8'd0;
        h.udp_sport = allowed_port;
        h.udp_dport = 16'd1024;
        h.tcp_flags = TCP_SYN | TCP_ACK;
        h.conf      = 1'b0;
        return h;
    endfunction

    // mostly well-formed headers with random content, some noise and
    // some headers broken in one place
    function automatic hdr_item_t random_header();
        hdr_item_t   h;
        int unsigned mode;
        int unsigned l4_bytes;
        int unsigned base;
        logic [7:0]  flag_menu [12];
        flag_menu = '{8'h00, TCP_ECE_CWR, TCP_SYN | TCP_FIN, TCP_SYN | TCP_RST,
                      TCP_FIN | TCP_PSH | TCP_URG, TCP_ACK, TCP_ACK | TCP_ECE_CWR,
                      TCP_SYN | TCP_ACK, TCP_PSH | TCP_ACK, TCP_SYN,
                      TCP_FIN | TCP_ACK, TCP_RST};
        mode = $urandom_range(0, 99);
        if (mode < 15)
        begin
            // noise: every field fully random
            h.src_addr  = $urandom;
            h.frag_word = 16'($urandom);
            h.proto     = 8'($urandom);
            h.hdr_words = 4'($urandom);
            h.pkt_len   = 16'($urandom);
            h.icmp_kind = 8'($urandom);
            h.udp_sport = 16'($urandom);
            h.udp_dport = 16'($urandom);
            h.tcp_flags = 8'($urandom);
            h.conf      = 1'($urandom);
            return h;
        end
        case ($urandom_range(0, 3))
            0:       h.proto = IP_PROTO_ICMP;
            1:       h.proto = IP_PROTO_UDP;
            2:       h.proto = IP_PROTO_TCP;
            default: h.proto = 8'($urandom);
        endcase
        // first octet 11..126 is never a spoofed range
        h.src_addr  = {8'($urandom_range(11, 126)), 24'($urandom)};
        h.frag_word = $urandom_range(0, 1) ? FRAG_DONT_FRAG : 16'h0000;
        h.hdr_words = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 4))
                                                  : 4'($urandom_range(5, 15));
        if (h.proto == IP_PROTO_TCP)
            l4_bytes = 32'(TCP_HDR_BYTES);
        else if (h.proto == IP_PROTO_ICMP || h.proto == IP_PROTO_UDP)
            l4_bytes = 32'(UDP_HDR_BYTES);
        else
            l4_bytes = 0;
        base = 32'(h.hdr_words) * 4 + l4_bytes;
        case ($urandom_range(0, 3))
            0:       h.pkt_len = 16'(base);
            1:       h.pkt_len = 16'(base + $urandom_range(1, 1400));
            default: h.pkt_len = 16'(base + $urandom_range(0, 40));
        endcase
        h.icmp_kind = $urandom_range(0, 1) ? ICMP_ECHO_REQUEST : 8'($urandom);
        h.udp_sport = 16'($urandom);
        h.udp_dport = 16'($urandom);
        case ($urandom_range(0, 2))
            0:       h.udp_sport = allowed_port;
            1:       h.udp_dport = allowed_port;
            default: ;
        endcase
        h.tcp_flags = ($urandom_range(0, 9) < 7) ? flag_menu[$urandom_range(0, 11)]
                                                  : 8'($urandom);
        h.conf = 1'($urandom);
        if (mode < 25)
        begin
            // break one thing
            case ($urandom_range(0, 2))
                0:
                begin
                    if (base > 0)
                        h.pkt_len = 16'($urandom_range(0, base - 1));
                end
                1:
                begin
                    case ($urandom_range(0, 4))
                        0:       h.src_addr = {8'h7F, 24'($urandom)};
                        1:       h.src_addr = {8'h0A, 24'($urandom)};
                        2:       h.src_addr = {12'hAC1, 20'($urandom)};
                        3:       h.src_addr = {4'hE, 28'($urandom)};
                        default: h.src_addr = 32'hFFFF_FFFF;
                    endcase
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        h.frag_word = h.frag_word | FRAG_MORE_MASK;
                    else
                        h.frag_word = h.frag_word | 16'($urandom_range(1, 16'h1FFF));
                end
            endcase
        end
        return h;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // present one header word, hold it until taken, queue its verdict
    task automatic send_header(input hdr_item_t h);
        @(negedge clk);
        start                <= 1'b1;
        source_address       <= h.src_addr;
        fragment_field       <= h.frag_word;
        protocol_number      <= h.proto;
        header_words         <= h.hdr_words;
        packet_length        <= h.pkt_len;
        icmp_type            <= h.icmp_kind;
        udp_source_port      <= h.udp_sport;
        udp_dest_port        <= h.udp_dport;
        tcp_flag_bits        <= h.tcp_flags;
        connection_confirmed <= h.conf;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_verdicts.push_back(predict_verdict(h, allowed_port));
        // random gap, each further idle cycle drawn on its own, otherwise
        // start stays high into the next word
        if (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            @(negedge clk);
            start <= 1'b0;
            while ($urandom_range(0, 99) < IDLE_PERCENT)
                @(negedge clk);
        end
    endtask

    // stop sending and wait for every queued verdict to come out
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // port register write, only with nothing in flight
    task automatic write_udp_port(input logic [15:0] port);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= port;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        allowed_port = port;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // reset value of the port register applies to either port
    task automatic test_reset_port();
        hdr_item_t h;
        h = clean_header(IP_PROTO_UDP);
        h.udp_sport = UDP_PORT_RESET;
        send_header(h);
        h.udp_sport = 16'd5353;
        h.udp_dport = UDP_PORT_RESET;
        send_header(h);
        h.udp_dport = 16'd54;
        send_header(h);
    endtask

    task automatic test_header_length();
        hdr_item_t h;
        // longest ip header, one byte missing
        h = clean_header(PROTO_UNLISTED);
        h.hdr_words = 4'd15;
        h.pkt_len   = 16'd59;
        send_header(h);
        // zero header length is taken as given, unknown protocol needs nothing
        h.hdr_words = 4'd0;
        h.pkt_len   = 16'd0;
        send_header(h);
        // icmp and tcp one byte short of their l4 header
        h = clean_header(IP_PROTO_ICMP);
        h.pkt_len = 16'd27;
        send_header(h);
        h = clean_header(IP_PROTO_TCP);
        h.pkt_len = 16'd39;
        send_header(h);
    endtask

    task automatic test_spoofed_source();
        hdr_item_t   h;
        logic [31:0] addr_list [6];
        addr_list = '{32'h7F00_0001, 32'h0A00_0000, 32'hAC1F_FFFF,
                      32'hAC20_0000, 32'hEFFF_FFFF, 32'hFFFF_FFFF};
        h = clean_header(IP_PROTO_TCP);
        foreach (addr_list[k])
        begin
            h.src_addr = addr_list[k];
            send_header(h);
        end
    endtask

    task automatic test_fragments();
        hdr_item_t h;
        h = clean_header(IP_PROTO_TCP);
        h.frag_word = FRAG_MORE_MASK;
        send_header(h);
        h.frag_word = FRAG_OFFSET_MASK;
        send_header(h);
        // reserved and dont-fragment bits alone do not make a fragment
        h.frag_word = 16'hC000;
        send_header(h);
    endtask

    task automatic test_icmp();
        hdr_item_t h;
        h = clean_header(IP_PROTO_ICMP);
        h.icmp_kind = ICMP_ECHO_REQUEST;
        send_header(h);
        h.icmp_kind = 8'hFF;
        send_header(h);
    endtask

    // scan flag patterns; ece and cwr alone are not a null scan, and a lone
    // ack ignores the upper two bits
    task automatic test_tcp_flags();
        hdr_item_t  h;
        logic [7:0] flag_list [8];
        logic       conf_list [8];
        flag_list = '{8'h00, TCP_ECE_CWR, TCP_SYN | TCP_FIN, TCP_SYN | TCP_RST,
                      TCP_FIN | TCP_PSH | TCP_URG, TCP_ACK, TCP_ACK,
                      TCP_ACK | TCP_ECE_CWR};
        conf_list = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
        h = clean_header(IP_PROTO_TCP);
        foreach (flag_list[k])
        begin
            h.tcp_flags = flag_list[k];
            h.conf      = conf_list[k];
            send_header(h);
        end
    endtask

    // port register at both extremes and a random value
    task automatic test_port_register();
        hdr_item_t   h;
        logic [15:0] port_list [3];
        port_list = '{16'h0000, 16'hFFFF, 16'($urandom)};
        foreach (port_list[k])
        begin
            write_udp_port(port_list[k]);
            h = clean_header(IP_PROTO_UDP);
            h.udp_sport = allowed_port;
            send_header(h);
            h.udp_sport = allowed_port + 16'd1;
            h.udp_dport = allowed_port;
            send_header(h);
            h.udp_dport = allowed_port + 16'd2;
            send_header(h);
            repeat (8) send_header(random_header());
        end
    endtask

    task automatic test_random_traffic();
        write_udp_port(16'($urandom));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // back-to-back stretch with no sender gaps
            gaps_on = !(i >= 150 && i < 300);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            if (i == (3 * RANDOM_ITEMS) / 4)
                write_udp_port(16'($urandom));
            send_header(random_header());
        end
        gaps_on = 1'b1;
    endtask

    // result checker, no back-pressure on this side
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
                note_mismatch($sformatf("unexpected result drop %0b reason %0d",
                                        drop_packet, drop_reason));
            else
            begin
                oldest_verdict = pending_verdicts.pop_front();
                if (drop_packet !== oldest_verdict.drop ||
                    drop_reason !== oldest_verdict.reason)
                    note_mismatch($sformatf("expected drop %0b reason %0d, got drop %0b reason %0d",
                                            oldest_verdict.drop, oldest_verdict.reason,
                                            drop_packet, drop_reason));
            end
        end
    end

    initial
    begin
        // every input known from time zero
        rst_n                = 1'b0;
        start                = 1'b0;
        source_address       = 32'd0;
        fragment_field       = 16'd0;
        protocol_number      = 8'd0;
        header_words         = 4'd0;
        packet_length        = 16'd0;
        icmp_type            = 8'd0;
        udp_source_port      = 16'd0;
        udp_dest_port        = 16'd0;
        tcp_flag_bits        = 8'd0;
        connection_confirmed = 1'b0;
        cfg_valid            = 1'b0;
        cfg_data             = 16'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_port();
        test_header_length();
        test_spoofed_source();
        test_fragments();
        test_icmp();
        test_tcp_flags();
        test_port_register();
        test_random_traffic();

        // the cycle limit catches verdicts that never arrive
        drain_results();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ihpf_pkg.sv
hdl/ihpf_front.sv
hdl/ihpf_queue.sv
hdl/ihpf_back.sv
hdl/ipv4_header_packet_filter.sv
tb/tb_ipv4_header_packet_filter.sv
